[rtl/rlerd_pkg.sv]
// ============================================================================
// rlerd_pkg : shared types and constants of the run-length row decoder
// Phase codes, status codes, register indexes and the result record.
// ============================================================================
package rlerd_pkg;

    // Decode phase codes
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_LITERAL = 2'd1;
    localparam logic [1:0] PH_VALUE   = 2'd2;
    localparam logic [1:0] PH_ENDED   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_STOP      = 2'd1;
    localparam logic [1:0] ST_OVERSHOOT = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_COMPRESSED = 2'd0;
    localparam logic [1:0] REG_WIDE       = 2'd1;
    localparam logic [1:0] REG_ROW_WIDTH  = 2'd2;

    // Header fields: bit 7 selects a literal run, low 7 bits hold the count
    localparam int unsigned HDR_LITERAL_BIT = 7;
    localparam int unsigned COUNT_W         = 7;
    localparam int unsigned COLUMN_W        = 17;
    localparam int unsigned WIDTH_W         = 16;

    typedef struct packed {
        logic [7:0]         pixel_value;
        logic [COUNT_W-1:0] repeat_count;
        logic               row_done;
        logic [1:0]         status;
    } t_result;

endpackage

[rtl/sgi_rle_row_decoder_core.sv]
// ============================================================================
// sgi_rle_row_decoder_core : run-length row decoder for one channel row
// Each result is registered in the output register, or the skid on a stall.
// Throughput: one code unit per cycle while the skid entry is empty; phase,
// count and column update in the accepting cycle, so units flow with no bubble.
// A two-entry output (register plus skid) keeps input ready while a result
// waits. Reset is synchronous, active low: raw mode, 8-bit units, width 1.
// ============================================================================
module sgi_rle_row_decoder_core
    import rlerd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,

    // code unit channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_code_unit,
    input  logic        i_row_start,

    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_pixel_value,
    output logic [6:0]  o_repeat_count,
    output logic        o_row_done,
    output logic [1:0]  o_status
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always accepted; ready is tied high.
    // ------------------------------------------------------------------
    logic               r_compressed;
    logic               r_wide;
    logic [WIDTH_W-1:0] r_row_width;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compressed <= 1'b0;
            r_wide       <= 1'b0;
            r_row_width  <= WIDTH_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_COMPRESSED: r_compressed <= i_cfg_data[0];
                REG_WIDE:       r_wide       <= i_cfg_data[0];
                REG_ROW_WIDTH:  r_row_width  <= i_cfg_data;
                default: ; // unused index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Row state
    // ------------------------------------------------------------------
    logic [1:0]          r_phase,     n_phase;
    logic [COUNT_W-1:0]  r_remaining, n_remaining;
    logic [COLUMN_W-1:0] r_column,    n_column;

    logic                in_accept;
    logic [1:0]          cur_phase;
    logic [COUNT_W-1:0]  cur_remaining;
    logic [COLUMN_W-1:0] cur_column;
    logic [COLUMN_W-1:0] eff_width;
    logic [7:0]          unit_pixel;
    logic [COUNT_W-1:0]  hdr_count;
    logic [COUNT_W-1:0]  emit_count;
    logic [COLUMN_W-1:0] emit_column;
    logic                emit_full;
    logic                res_valid;
    t_result             res;

    assign in_accept = i_in_valid && o_in_ready;

    // A row start clears the row state before this unit decodes
    assign cur_phase     = i_row_start ? PH_HEADER : r_phase;
    assign cur_remaining = i_row_start ? '0 : r_remaining;
    assign cur_column    = i_row_start ? '0 : r_column;

    // A zero width behaves as a width of one
    assign eff_width  = (r_row_width == '0) ? COLUMN_W'(1) : {1'b0, r_row_width};
    // Wide units keep their high byte
    assign unit_pixel = r_wide ? i_code_unit[15:8] : i_code_unit[7:0];
    assign hdr_count  = i_code_unit[COUNT_W-1:0];

    // Value runs add their whole count, raw and literal pixels add one
    assign emit_count  = (r_compressed && cur_phase == PH_VALUE) ? cur_remaining
                                                                 : COUNT_W'(1);
    assign emit_column = cur_column + COLUMN_W'(emit_count);
    assign emit_full   = (emit_column >= eff_width);

    always_comb begin
        n_phase          = cur_phase;
        n_remaining      = cur_remaining;
        n_column         = cur_column;
        res_valid        = 1'b0;
        res.pixel_value  = unit_pixel;
        res.repeat_count = emit_count;
        res.row_done     = emit_full;
        res.status       = (emit_column > eff_width) ? ST_OVERSHOOT : ST_OK;

        if (cur_phase == PH_ENDED) begin
            // row already finished: ignore the unit
            res_valid = 1'b0;
        end else if (!r_compressed) begin
            // raw mode: every unit is a pixel, whatever the phase
            res_valid   = 1'b1;
            n_remaining = '0;
            n_column    = emit_column;
            n_phase     = emit_full ? PH_ENDED : PH_HEADER;
        end else begin
            case (cur_phase)
                PH_HEADER: begin
                    if (hdr_count == '0) begin
                        // zero count: stop marker ends the row
                        res_valid        = 1'b1;
                        res.pixel_value  = '0;
                        res.repeat_count = '0;
                        res.row_done     = (cur_column >= eff_width);
                        res.status       = ST_STOP;
                        n_phase          = PH_ENDED;
                    end else begin
                        n_remaining = hdr_count;
                        n_phase     = i_code_unit[HDR_LITERAL_BIT] ? PH_LITERAL : PH_VALUE;
                    end
                end
                PH_LITERAL: begin
                    // a literal run is consumed to its end even past the width
                    res_valid   = 1'b1;
                    n_column    = emit_column;
                    n_remaining = cur_remaining - COUNT_W'(1);
                    if (n_remaining == '0) begin
                        n_phase = emit_full ? PH_ENDED : PH_HEADER;
                    end
                end
                default: begin
                    // repeat value: one result carries the whole run
                    res_valid   = 1'b1;
                    n_column    = emit_column;
                    n_remaining = '0;
                    n_phase     = emit_full ? PH_ENDED : PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_remaining <= '0;
            r_column    <= '0;
        end else if (in_accept) begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_column    <= n_column;
        end
    end

    // ------------------------------------------------------------------
    // Output register with a skid entry. Input ready depends only on the
    // skid entry being empty, so the two sides stay decoupled.
    // ------------------------------------------------------------------
    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                // drain the skid entry; no beat was accepted this cycle
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_accept && res_valid;
            end
        end else if (in_accept && res_valid) begin
            // output stalled: hold the new result in the skid entry
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : res;
        end
        if (!out_free && in_accept && res_valid) begin
            r_skid <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_value  = r_out.pixel_value;
    assign o_repeat_count = r_out.repeat_count;
    assign o_row_done     = r_out.row_done;
    assign o_status       = r_out.status;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a result while the output is empty");

    a_literal_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LITERAL || r_phase == PH_VALUE) |-> (r_remaining != '0))
        else $error("run phase with zero remaining count");

    a_stop_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_STOP) |-> (o_repeat_count == '0 && o_pixel_value == '0))
        else $error("stop marker carries a nonzero pixel or count");

    a_ended_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !i_row_start && r_phase == PH_ENDED) |-> !res_valid)
        else $error("unit after row end produced a result");

endmodule

[test/sgi_rle_row_decoder_core_tb.sv]
// ============================================================================
// sgi_rle_row_decoder_core_tb : self-checking bench for the run-length row decoder
// Walk a short table of directed code units and register writes, then stream
// random rows (mostly well-formed runs, some noise) through several register
// settings. A local decoder predicts every result; the result port is checked
// beat by beat, field by field, under random stalls on both channels.
// ============================================================================
module sgi_rle_row_decoder_core_tb
    import rlerd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CLK_HALF     = 6;
    localparam int unsigned RANDOM_UNITS = 1400;
    localparam int unsigned SETTLE       = 4;    // output register plus skid entry
    localparam int unsigned LONG_HOLD    = 300;  // receiver hold-off, in cycles
    localparam int unsigned HOLD_EVERY   = 600;  // results between hold-offs

    // ------------------------------------------------------------------------
    // Clock, DUT ports
    // ------------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = REG_COMPRESSED;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [15:0] i_code_unit = '0;
    logic        i_row_start = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_pixel_value;
    logic [6:0]  o_repeat_count;
    logic        o_row_done;
    logic [1:0]  o_status;

    always #(CLK_HALF) i_clk = ~i_clk;

    sgi_rle_row_decoder_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_code_unit    (i_code_unit),
        .i_row_start    (i_row_start),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pixel_value  (o_pixel_value),
        .o_repeat_count (o_repeat_count),
        .o_row_done     (o_row_done),
        .o_status       (o_status)
    );

    // ------------------------------------------------------------------------
    // Decoder prediction: register copies and row state
    // ------------------------------------------------------------------------
    logic        cfg_compressed = 1'b0;
    logic        cfg_wide       = 1'b0;
    logic [16:0] cfg_row_limit  = 17'd1;   // row width, zero taken as one

    logic [1:0]         dec_phase = PH_HEADER;
    logic [COUNT_W-1:0] run_left  = '0;    // literal units left, or repeat count
    logic [16:0]        col_cnt   = '0;

    t_result due_results[$];   // expected beats, oldest first

    int unsigned n_fail         = 0;
    int unsigned n_units_decoded = 0;     // units that were not ignored
    int unsigned n_results_seen = 0;
    int unsigned n_rows_done    = 0;
    int unsigned n_stops        = 0;
    int unsigned n_overshoots   = 0;
    int unsigned n_long_holds   = 0;
    bit          calm_sender    = 1'b0;   // no gaps on the code unit side

    // Advance the column count by n pixels and fill one result.
    function automatic bit add_pixels(input logic [7:0] pix, input logic [6:0] n,
                                      output t_result res);
        col_cnt          = col_cnt + 17'(n);
        res.pixel_value  = pix;
        res.repeat_count = n;
        res.row_done     = (col_cnt >= cfg_row_limit);
        res.status       = (col_cnt > cfg_row_limit) ? ST_OVERSHOOT : ST_OK;
        return col_cnt >= cfg_row_limit;
    endfunction

    // Decode one code unit; return 1 when it produces a result beat.
    function automatic bit decode_unit(input logic [15:0] unit, input logic rs,
                                       output t_result res, output bit ignored);
        logic [7:0] hdr;
        logic [7:0] pix;
        bit         full;
        res     = '0;
        ignored = 1'b0;
        if (rs) begin
            dec_phase = PH_HEADER;
            run_left  = '0;
            col_cnt   = '0;
        end
        if (dec_phase == PH_ENDED) begin
            ignored = 1'b1;
            return 1'b0;
        end
        // wide units keep their high byte, byte units live in the low byte
        pix = cfg_wide ? unit[15:8] : unit[7:0];
        if (!cfg_compressed) begin
            // raw rows: every unit is a pixel, whatever phase was pending
            run_left  = '0;
            full      = add_pixels(pix, 7'd1, res);
            dec_phase = full ? PH_ENDED : PH_HEADER;
            return 1'b1;
        end
        case (dec_phase)
            PH_HEADER: begin
                hdr = unit[7:0];
                if (hdr[6:0] == '0) begin
                    // zero count: stop marker ends the row
                    res.pixel_value  = '0;
                    res.repeat_count = '0;
                    res.row_done     = (col_cnt >= cfg_row_limit);
                    res.status       = ST_STOP;
                    dec_phase        = PH_ENDED;
                    return 1'b1;
                end
                run_left  = hdr[6:0];
                dec_phase = hdr[HDR_LITERAL_BIT] ? PH_LITERAL : PH_VALUE;
                return 1'b0;
            end
            PH_LITERAL: begin
                full     = add_pixels(pix, 7'd1, res);
                run_left = run_left - COUNT_W'(1);
                // a run that crosses the width is consumed to its end
                if (run_left == '0) dec_phase = full ? PH_ENDED : PH_HEADER;
                return 1'b1;
            end
            default: begin
                full      = add_pixels(pix, run_left, res);
                run_left  = '0;
                dec_phase = full ? PH_ENDED : PH_HEADER;
                return 1'b1;
            end
        endcase
    endfunction

    // Mostly short gaps, a few long ones.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Random header: mostly short runs, some long, a rare zero count.
    function automatic logic [15:0] random_header();
        logic [31:0] rnd;
        logic [6:0]  cnt;
        int unsigned r;
        rnd = $urandom;
        r   = $urandom_range(0, 99);
        if (r < 4)       cnt = '0;
        else if (r < 64) cnt = 7'($urandom_range(1, 6));
        else if (r < 92) cnt = 7'($urandom_range(7, 40));
        else             cnt = 7'($urandom_range(41, 127));
        return {rnd[15:8], rnd[16], cnt};
    endfunction

    // ------------------------------------------------------------------------
    // Drivers: inputs change on the falling edge only
    // ------------------------------------------------------------------------

    // Predict one unit, queue its expectation, then offer it until accepted.
    // A known result, when given, replaces the predicted one.
    task automatic issue_item(input logic [15:0] unit, input logic rs,
                              input bit known, input t_result known_res);
        t_result res;
        bit      ignored;
        bit      has_res;
        int unsigned gap;
        has_res = decode_unit(unit, rs, res, ignored);
        if (known) due_results.push_back(known_res);
        else if (has_res) due_results.push_back(res);
        if (!ignored) n_units_decoded++;
        gap = calm_sender ? 0 : idle_len();
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid  = 1'b1;
        i_code_unit = unit;
        i_row_start = rs;
        // hold the beat until the decoder takes it
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drain every expected result, let the output stage settle, then write.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_COMPRESSED: cfg_compressed = data[0];
            REG_WIDE:       cfg_wide       = data[0];
            REG_ROW_WIDTH:  cfg_row_limit  = (data == '0) ? 17'd1 : 17'(data);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Directed table: register writes and code units, in order
    // ------------------------------------------------------------------------
    typedef enum logic {STEP_UNIT, STEP_CFG} t_step_kind;

    typedef struct packed {
        t_step_kind  kind;
        logic [1:0]  reg_idx;
        logic [15:0] value;
        logic        row_start;
        logic        known;
        t_result     want;
    } t_plan_row;

    t_plan_row plan[$];

    function automatic void plan_cfg(input logic [1:0] idx, input logic [15:0] value);
        plan.push_back('{STEP_CFG, idx, value, 1'b0, 1'b0, t_result'('0)});
    endfunction

    function automatic void plan_unit(input logic [15:0] value, input logic rs);
        plan.push_back('{STEP_UNIT, REG_COMPRESSED, value, rs, 1'b0, t_result'('0)});
    endfunction

    function automatic void plan_known(input logic [15:0] value, input logic rs,
                                       input logic [7:0] pix, input logic [6:0] cnt,
                                       input logic done, input logic [1:0] st);
        plan.push_back('{STEP_UNIT, REG_COMPRESSED, value, rs, 1'b1,
                         t_result'({pix, cnt, done, st})});
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: compare each beat with the oldest expectation
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("time %0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
            n_fail++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_pixel_value, o_repeat_count, o_row_done, o_status};
            n_results_seen++;
            if (got.row_done === 1'b1)        n_rows_done++;
            if (got.status === ST_STOP)       n_stops++;
            if (got.status === ST_OVERSHOOT)  n_overshoots++;
            if (due_results.size() == 0) begin
                $display("time %0t: unexpected result, expected none, actual %0h",
                         $time, got);
                n_fail++;
            end else begin
                want = due_results.pop_front();
                check_field("pixel_value",  want.pixel_value,         got.pixel_value);
                check_field("repeat_count", 8'(want.repeat_count),    8'(got.repeat_count));
                check_field("row_done",     8'(want.row_done),        8'(got.row_done));
                check_field("status",       8'(want.status),          8'(got.status));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result sink: random ready, plus long hold-offs that back up the input
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned next_hold_at;
        int unsigned stall;
        next_hold_at = 150;
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            if (n_results_seen >= next_hold_at) begin
                // hold ready low while the sender keeps offering units
                next_hold_at += HOLD_EVERY;
                n_long_holds++;
                repeat (LONG_HOLD) begin
                    @(negedge i_clk);
                    i_out_ready = 1'b0;
                end
            end
            stall = ($urandom_range(0, 2) == 0) ? idle_len() : 0;
            repeat (stall) begin
                @(negedge i_clk);
                i_out_ready = 1'b0;
            end
            repeat ($urandom_range(1, 24)) begin
                @(negedge i_clk);
                i_out_ready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial begin : watchdog
        #(10_000_000);
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        logic [15:0] unit;
        logic        rs;
        logic [31:0] rnd;
        bit          fresh;
        int unsigned phase_len;
        int unsigned r;

        // Reset state: raw rows, byte units, width 1
        plan_known(16'h00ff, 1'b1, 8'hff, 7'd1, 1'b1, ST_OK);
        plan_unit (16'h1234, 1'b0);                          // row already ended
        plan_known(16'hff00, 1'b1, 8'h00, 7'd1, 1'b1, ST_OK);
        plan_cfg  (REG_ROW_WIDTH, 16'd0);                    // zero width acts as one
        plan_known(16'ha5a5, 1'b1, 8'ha5, 7'd1, 1'b1, ST_OK);
        // Compressed rows of width 10: literal run, repeat run, long repeat
        plan_cfg  (REG_COMPRESSED, 16'd1);
        plan_cfg  (REG_ROW_WIDTH, 16'd10);
        plan_unit (16'h0083, 1'b1);
        plan_unit (16'h0011, 1'b0);
        plan_unit (16'h00ee, 1'b0);
        plan_unit (16'hff22, 1'b0);
        plan_unit (16'h0005, 1'b0);
        plan_unit (16'h00ab, 1'b0);
        plan_unit (16'h007f, 1'b0);
        plan_known(16'h0055, 1'b0, 8'h55, 7'd127, 1'b1, ST_OVERSHOOT);
        plan_unit (16'h0081, 1'b0);                          // ignored after row end
        // Stop markers, with and without the literal bit
        plan_known(16'h0000, 1'b1, 8'h00, 7'd0, 1'b0, ST_STOP);
        plan_known(16'hff80, 1'b1, 8'h00, 7'd0, 1'b0, ST_STOP);
        // Literal run crossing a width of 2
        plan_cfg  (REG_ROW_WIDTH, 16'd2);
        plan_unit (16'h0084, 1'b1);
        plan_unit (16'h0001, 1'b0);
        plan_unit (16'h0002, 1'b0);
        plan_unit (16'h0003, 1'b0);
        plan_unit (16'h0004, 1'b0);
        // Wide units, widest row, mode switch inside a literal run
        plan_cfg  (REG_WIDE, 16'd1);
        plan_cfg  (REG_ROW_WIDTH, 16'hffff);
        plan_unit (16'h0083, 1'b1);
        plan_unit (16'hbeef, 1'b0);
        plan_cfg  (REG_COMPRESSED, 16'd0);
        plan_unit (16'hffff, 1'b0);
        plan_cfg  (REG_COMPRESSED, 16'd1);
        plan_unit (16'hc002, 1'b0);                          // header from low byte
        plan_unit (16'h7700, 1'b0);

        // Reset: hold it low, then release on a falling edge
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == STEP_CFG) write_reg(plan[i].reg_idx, plan[i].value);
            else issue_item(plan[i].value, plan[i].row_start, plan[i].known, plan[i].want);
        end

        // Random rows across many register settings
        n_units_decoded = 0;
        while (n_units_decoded < RANDOM_UNITS) begin
            write_reg(REG_COMPRESSED, 16'($urandom_range(0, 3) != 0));
            write_reg(REG_WIDE, 16'($urandom_range(0, 1)));
            r = $urandom_range(0, 19);
            if (r == 0)      write_reg(REG_ROW_WIDTH, 16'hffff);
            else if (r == 1) write_reg(REG_ROW_WIDTH, 16'd0);
            else if (r < 4)  write_reg(REG_ROW_WIDTH, 16'd1);
            else             write_reg(REG_ROW_WIDTH, 16'($urandom_range(2, 40)));
            calm_sender = ($urandom_range(0, 3) == 0);
            // sometimes carry the row on, so a mode change lands mid-row
            fresh     = ($urandom_range(0, 3) != 0);
            phase_len = (cfg_row_limit == 17'hffff) ? $urandom_range(20, 60)
                                                   : $urandom_range(40, 140);
            repeat (phase_len) begin
                rnd = $urandom;
                if ($urandom_range(0, 99) < 6) begin
                    // noise: any unit, sometimes a stray row start
                    unit = rnd[15:0];
                    rs   = ($urandom_range(0, 3) == 0);
                end else if (fresh || dec_phase == PH_ENDED) begin
                    unit = cfg_compressed ? random_header() : rnd[15:0];
                    rs   = 1'b1;
                end else if (cfg_compressed && dec_phase == PH_HEADER) begin
                    unit = random_header();
                    rs   = 1'b0;
                end else begin
                    unit = rnd[15:0];
                    rs   = 1'b0;
                end
                fresh = 1'b0;
                issue_item(unit, rs, 1'b0, t_result'('0));
            end
        end

        // Drop valid, drain, and give the output stage time to settle
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE * 4) @(posedge i_clk);

        $display("Decoded %0d random units; %0d results checked: %0d rows done, %0d stops,",
                 n_units_decoded, n_results_seen, n_rows_done, n_stops);
        $display("%0d overshooting pixels, %0d long receiver hold-offs.",
                 n_overshoots, n_long_holds);
        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[files.f]
rtl/rlerd_pkg.sv
rtl/sgi_rle_row_decoder_core.sv
test/sgi_rle_row_decoder_core_tb.sv
